// ===== sv/sorted_table_binary_search_top_defines.svh =====
// Assertion macros used by the sorted table search controller.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stbs_pkg.sv =====
// Package with shared types and constants of the sorted table search block.
package stbs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int VALUE_W = 32;
  localparam int POS_W = 10;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflowed;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic probe;   // latch the midpoint and read the table there
    logic step;    // compare the read entry and narrow the range
    logic finish;  // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;  // low > up
    logic hit;          // read entry equals the key
    logic out_busy;     // result register holds a beat that is not taken
  } dp_status_t;

endpackage

// ===== sv/stbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/stbs_dp.sv =====
// Datapath: table storage, fill count, search range registers and result register.
module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_accept,
  input  stbs_pkg::in_beat_t    in_data,
  input  stbs_pkg::dp_cmd_t     cmd,
  output stbs_pkg::dp_status_t  status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output stbs_pkg::out_beat_t   out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CW-1:0]                       count;
  logic                                overflow;
  logic signed [stbs_pkg::VALUE_W-1:0] key;
  logic [CW-1:0]                       low;
  logic signed [CW:0]                  up;
  logic [CW-1:0]                       mid;
  logic [CW-1:0]                       mid_calc;
  logic [CW:0]                         mid_sum;
  logic                                found;
  logic [stbs_pkg::POS_W-1:0]          pos;
  logic                                full;
  logic                                ram_we;
  logic [stbs_pkg::VALUE_W-1:0]        ram_rdata;
  logic signed [stbs_pkg::VALUE_W-1:0] entry;

  assign full     = (count == CW'(TABLE_DEPTH));
  assign ram_we   = in_accept && (in_data.mode == stbs_pkg::MODE_APPEND) && !full;
  // Only taken while the range is non-empty, so up is not negative here.
  assign mid_sum  = {1'b0, low} + {1'b0, up[CW-1:0]};
  assign mid_calc = mid_sum[CW:1];
  assign entry    = $signed(ram_rdata);

  assign status.range_empty = $signed({1'b0, low}) > up;
  assign status.hit         = (entry == key);
  assign status.out_busy    = out_valid && !out_ready;

  stbs_ram #(
    .WIDTH(stbs_pkg::VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(in_data.value),
    .re   (cmd.probe),
    .raddr(mid_calc[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        unique case (in_data.mode)
          stbs_pkg::MODE_CLEAR: begin
            count    <= '0;
            overflow <= 1'b0;
          end
          stbs_pkg::MODE_APPEND: begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search registers carry no reset: each search starts by loading them.
  always_ff @(posedge clk) begin
    if (in_accept && (in_data.mode == stbs_pkg::MODE_SEARCH)) begin
      key   <= in_data.value;
      low   <= '0;
      up    <= $signed({1'b0, count} - (CW+1)'(1));
      found <= 1'b0;
      pos   <= '0;
    end else begin
      if (cmd.probe) begin
        mid <= mid_calc;
      end
      if (cmd.step) begin
        if (status.hit) begin
          found <= 1'b1;
          pos   <= stbs_pkg::POS_W'(mid);
        end else if (entry < key) begin
          low <= mid + 1'b1;
        end else begin
          up <= $signed({1'b0, mid} - (CW+1)'(1));
        end
      end
    end
    if (cmd.finish) begin
      out_data.found      <= found;
      out_data.position   <= pos;
      out_data.overflowed <= overflow;
    end
  end

endmodule

// ===== sv/stbs_ctrl.sv =====
// Controller: sequences the probes of one search and hands off the result.
`include "sorted_table_binary_search_top_defines.svh"

module stbs_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [stbs_pkg::MODE_W-1:0] in_mode,
  output logic                       in_ready,
  input  stbs_pkg::dp_status_t       status,
  output stbs_pkg::dp_cmd_t          cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_WAIT,
    S_FIN
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.probe  = (state == S_PROBE) && !status.range_empty;
  assign cmd.step   = (state == S_WAIT);
  assign cmd.finish = (state == S_FIN) && !status.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_mode == stbs_pkg::MODE_SEARCH) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= status.range_empty ? S_FIN : S_WAIT;
        end
        S_WAIT: begin
          state <= status.hit ? S_FIN : S_PROBE;
        end
        S_FIN: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STBS_ASSERT_NEXT(a_search_starts, in_valid && in_ready && in_mode == stbs_pkg::MODE_SEARCH, state == S_PROBE, "search beat did not start a probe")
  `STBS_ASSERT_NOW(a_wait_after_probe, state == S_WAIT, $past(cmd.probe), "compare without a table read")
  `STBS_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state == S_IDLE && !cmd.finish, "result loaded twice or block stuck")

endmodule

// ===== sv/sorted_table_binary_search_top.sv =====
// Top level of the sorted table binary search block.
//
//   channel | signals                      | beat carries
//   --------+------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data   | mode (clear/append/search), value
//   output  | out_valid, out_ready, out_data| found, position, overflowed
//
// Clear and append leave the input ready; only a search yields an output beat.
// A search probes the table until the key is hit or the range is empty, and
// the next item is taken once its result is loaded into the output register:
// each probe is a registered table read followed by a compare and range update.
// Input is stalled while a search runs; a finished result waits in the
// output register and the next item is taken while it waits. A search that
// ends while an earlier beat still waits holds in its last state until taken.
// Reset empties the table and clears the overflow flag; no clearing pass.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  stbs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stbs_pkg::out_beat_t out_data
);

  stbs_pkg::dp_cmd_t    cmd;
  stbs_pkg::dp_status_t status;
  logic                 in_accept;

  assign in_accept = in_valid && in_ready;

  stbs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_mode (in_data.mode),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_accept(in_accept),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
